// ===== hw/rtl/upd_pkg.sv =====
// Shared types, character codes and the hex digit decoder for the URL decoder.
// Depends on nothing; compile first.
package upd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] HEX_TEN    = 8'd10;

	// Most bytes one input word can give rise to.
	localparam int MAX_OUT = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	// One front-end command: up to three bytes to send, in order from index 0.
	typedef struct packed {
		logic [1:0]               cnt;
		logic [MAX_OUT-1:0][7:0] bytes;
		logic                     last;
	} cmd_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t       r;
		logic [7:0] d;
		begin
			r = '0;
			d = '0;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				d = c - CH_ZERO;
				r.ok = 1'b1;
			end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
				d = c - CH_LOWER_A + HEX_TEN;
				r.ok = 1'b1;
			end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
				d = c - CH_UPPER_A + HEX_TEN;
				r.ok = 1'b1;
			end
			r.nib = d[3:0];
			return r;
		end
	endfunction

endpackage

// ===== hw/rtl/upd_stream_if.sv =====
// Valid/ready stream interface with a payload of any packed type.
// Depends on nothing.
interface upd_stream_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/url_percent_decoder.sv =====
// Top level of the form-urlencoded percent decoder: front end, queue, back end.
// Depends on upd_pkg, upd_stream_if, upd_front, upd_queue and upd_back.
//
//   channel   dir   payload              accepted when
//   encoded   sink  in_byte, in_last     encoded.valid && encoded.ready
//   decoded   src   out_byte, out_last   decoded.valid && decoded.ready
//
// Cycles: one encoded word per cycle while the queue has room; each word yields
// zero to three decoded words, played out by the back end from its output
// register. A one-byte word passes from the queue into that register, then onto
// decoded; the back end's one-byte-per-cycle port sets the output rate while
// decoded.ready is high. Reset: arst_n clears the held escape state, the queue
// pointers and the output valid; no clearing pass. Stalls: decoded.ready low
// holds the back end, the queue fills, and encoded.ready drops only when full.
module url_percent_decoder
	import upd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	upd_stream_if.sink   encoded,
	upd_stream_if.source decoded
);

	// Commands from the front end into the queue, and from the queue onwards.
	upd_stream_if #(.item_t(cmd_t)) front_cmd ();
	upd_stream_if #(.item_t(cmd_t)) back_cmd ();

	// Classify each word, hold '%' and a first digit, build byte commands.
	upd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.encoded (encoded),
		.cmd     (front_cmd)
	);

	// Decouple the two sides so a stalled output does not stop intake at once.
	upd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (front_cmd),
		.rd     (back_cmd)
	);

	// Advance through each command's bytes and mark the final one of a string.
	upd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (back_cmd),
		.decoded (decoded)
	);

endmodule

// ===== hw/rtl/upd_front.sv =====
// Front end: holds escape state, classifies each input word into a command.
// Depends on upd_pkg and upd_stream_if.
module upd_front
	import upd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	upd_stream_if.sink     encoded,
	upd_stream_if.source   cmd
);

	typedef enum logic [1:0] {
		HOLD_NONE  = 2'd0,
		HOLD_PCT   = 2'd1,
		HOLD_DIGIT = 2'd2
	} hold_t;

	hold_t      held_q, held_d;
	logic [7:0] digit_q, digit_d;
	cmd_t       cmd_d;
	logic [1:0] n;
	logic       do_fresh;
	logic [7:0] c;
	hex_t       hv, hh;
	logic       take;

	always_comb begin
		c        = encoded.data.in_byte;
		hv       = hex_decode(c);
		hh       = hex_decode(digit_q);
		held_d   = held_q;
		digit_d  = digit_q;
		cmd_d    = '0;
		n        = '0;
		do_fresh = 1'b0;

		case (held_q)
			HOLD_PCT: begin
				if (hv.ok) begin
					held_d  = HOLD_DIGIT;
					digit_d = c;
				end else begin
					cmd_d.bytes[n] = CH_PERCENT;
					n = n + 2'd1;
					do_fresh = 1'b1;
				end
			end
			HOLD_DIGIT: begin
				if (hv.ok) begin
					held_d = HOLD_NONE;
					cmd_d.bytes[n] = {hh.nib, hv.nib};
					n = n + 2'd1;
				end else begin
					cmd_d.bytes[n] = CH_PERCENT;
					n = n + 2'd1;
					cmd_d.bytes[n] = digit_q;
					n = n + 2'd1;
					do_fresh = 1'b1;
				end
			end
			default: begin
				do_fresh = 1'b1;
			end
		endcase

		// Byte handled as if nothing were held.
		if (do_fresh) begin
			held_d = HOLD_NONE;
			if (c == CH_PERCENT) begin
				held_d = HOLD_PCT;
			end else if (n < 2'd3) begin
				cmd_d.bytes[n] = (c == CH_PLUS) ? CH_SPACE : c;
				n = n + 2'd1;
			end
		end

		// End of string: flush whatever is still held.
		if (encoded.data.in_last) begin
			if ((held_d == HOLD_PCT || held_d == HOLD_DIGIT) && n < 2'd3) begin
				cmd_d.bytes[n] = CH_PERCENT;
				n = n + 2'd1;
			end
			if (held_d == HOLD_DIGIT && n < 2'd3) begin
				cmd_d.bytes[n] = digit_d;
				n = n + 2'd1;
			end
			held_d  = HOLD_NONE;
			digit_d = '0;
		end

		cmd_d.cnt  = n;
		cmd_d.last = encoded.data.in_last;
	end

	assign encoded.ready = cmd.ready;
	assign take          = encoded.valid && encoded.ready;
	assign cmd.valid     = encoded.valid && (cmd_d.cnt != 2'd0);
	assign cmd.data      = cmd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= HOLD_NONE;
			digit_q <= '0;
		end else if (take) begin
			held_q  <= held_d;
			digit_q <= digit_d;
		end
	end

endmodule

// ===== hw/rtl/upd_queue.sv =====
// Short command queue between front and back ends.
// Depends on upd_pkg and upd_stream_if.
module upd_queue
	import upd_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	upd_stream_if.sink   wr,
	upd_stream_if.source rd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          push, pop;

	assign wr.ready = (cnt_q != CW'(DEPTH));
	assign rd.valid = (cnt_q != '0);
	assign rd.data  = mem_q[rd_q];
	assign push     = wr.valid && wr.ready;
	assign pop      = rd.valid && rd.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/upd_back.sv =====
// Back end: plays each command out one byte per word from an output register.
// Depends on upd_pkg and upd_stream_if.
module upd_back
	import upd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	upd_stream_if.sink   cmd,
	upd_stream_if.source decoded
);

	cmd_t       cmd_q;
	logic       busy_q;
	logic [1:0] pos_q;
	logic [1:0] last_pos;
	logic       at_end;
	logic       take;
	logic       sent;

	assign last_pos  = cmd_q.cnt - 2'd1;
	assign at_end    = (pos_q == last_pos);
	assign cmd.ready = !busy_q || (decoded.ready && at_end);
	assign take      = cmd.valid && cmd.ready;
	assign sent      = decoded.valid && decoded.ready;

	assign decoded.valid         = busy_q;
	assign decoded.data.out_byte = cmd_q.bytes[pos_q];
	assign decoded.data.out_last = cmd_q.last && at_end;

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (sent) begin
			if (at_end) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

endmodule
